>>> design/relay_image_shift_out_with_cycle_count_unit_defines.svh
// Assertion macros shared by the relay image shift-out design files.
`ifndef RELAY_IMAGE_SHIFT_OUT_WITH_CYCLE_COUNT_UNIT_DEFINES_SVH
`define RELAY_IMAGE_SHIFT_OUT_WITH_CYCLE_COUNT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define RLYSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define RLYSH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RLYSH_ASSERT_IMP(lbl, ante, cons)
`define RLYSH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/rlysh_pkg.sv
// Shared constants, codes and controller/datapath interface types of the relay image unit.
package rlysh_pkg;

  localparam int IO_BYTES    = 4;
  localparam int THERM_BYTES = 2;
  localparam int INPUT_BYTES = 2;
  localparam int CHANNELS    = 64;
  localparam int CNT_W       = 32;

  localparam int TOTAL_BYTES = IO_BYTES + THERM_BYTES + INPUT_BYTES;
  localparam int IO_FIRST    = 0;
  localparam int THERM_FIRST = IO_FIRST + IO_BYTES;
  localparam int INPUT_FIRST = THERM_FIRST + THERM_BYTES;
  localparam int IMG_BITS    = TOTAL_BYTES * 8;
  localparam int IMG_AW      = (IMG_BITS > 1) ? $clog2(IMG_BITS) : 1;
  localparam int BYTE_AW     = (TOTAL_BYTES > 1) ? $clog2(TOTAL_BYTES) : 1;
  localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] MODE_SET       = 3'd0;
  localparam logic [2:0] MODE_CLR       = 3'd1;
  localparam logic [2:0] MODE_FLUSH     = 3'd2;
  localparam logic [2:0] MODE_CLR_FLUSH = 3'd3;
  localparam logic [2:0] MODE_READ      = 3'd4;

  localparam logic [1:0] BOARD_INPUT = 2'd0;
  localparam logic [1:0] BOARD_THERM = 2'd1;
  localparam logic [1:0] BOARD_IO    = 2'd2;

  typedef struct packed {
    logic set_bit;
    logic clear_img;
    logic flush_init;
    logic shift_en;
    logic walk_en;
    logic copy_prev;
    logic rd_cnt;
    logic emit_cnt;
  } cmd_t;

  typedef struct packed {
    logic byte_last;
    logic walk_last;
  } sts_t;

endpackage

>>> design/rlysh_ctrl.sv
// Sequencing state machine of the relay image unit.
module rlysh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_mode,
  input  rlysh_pkg::sts_t   sts,
  output logic              busy,
  output rlysh_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.set_bit    = (in_mode == rlysh_pkg::MODE_SET);
          cmd.clear_img  = (in_mode inside {rlysh_pkg::MODE_CLR, rlysh_pkg::MODE_CLR_FLUSH});
          cmd.flush_init = (in_mode inside {rlysh_pkg::MODE_FLUSH, rlysh_pkg::MODE_CLR_FLUSH});
          cmd.rd_cnt     = (in_mode == rlysh_pkg::MODE_READ);
          if (cmd.flush_init) begin
            state_nxt = ST_SHIFT;
          end else if (cmd.rd_cnt) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (sts.byte_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.copy_prev = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        cmd.emit_cnt = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/rlysh_dp.sv
// Image registers, counter memory and result registers of the relay image unit.
`include "relay_image_shift_out_with_cycle_count_unit_defines.svh"
module rlysh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlysh_pkg::cmd_t               cmd,
  input  logic [5:0]                    in_channel,
  input  logic                          in_turn_on,
  output rlysh_pkg::sts_t               sts,
  output logic                          out_valid,
  output logic [7:0]                    out_shift_byte,
  output logic [1:0]                    out_board_select,
  output logic                          out_latch_after,
  output logic                          out_last_of_run,
  output logic                          out_count_valid,
  output logic [rlysh_pkg::CNT_W-1:0]   out_switch_count
);

  logic [rlysh_pkg::IMG_BITS-1:0]   img_r;
  logic [rlysh_pkg::IMG_BITS-1:0]   prev_r;
  logic [rlysh_pkg::BYTE_AW-1:0]    idx_r;
  logic [rlysh_pkg::CH_AW-1:0]      walk_r;

  logic [rlysh_pkg::CNT_W-1:0]      cnt_mem_r [rlysh_pkg::CHANNELS];
  logic [rlysh_pkg::CHANNELS-1:0]   cnt_vld_r;
  logic [rlysh_pkg::CNT_W-1:0]      rd_data_r;
  logic                             rd_vld_r;
  logic                             rd_in_range_r;
  logic [rlysh_pkg::CH_AW-1:0]      rd_addr;

  logic                             wb_vld_r;
  logic                             wb_rise_r;
  logic [rlysh_pkg::CH_AW-1:0]      wb_addr_r;
  logic                             rise;
  logic                             ch_in_img;

  logic                             out_valid_r;
  logic [7:0]                       out_shift_byte_r;
  logic [1:0]                       out_board_select_r;
  logic                             out_latch_after_r;
  logic                             out_last_of_run_r;
  logic                             out_count_valid_r;
  logic [rlysh_pkg::CNT_W-1:0]      out_switch_count_r;

  assign ch_in_img     = (int'(in_channel) < rlysh_pkg::IMG_BITS);
  assign sts.byte_last = (idx_r == '0);
  assign sts.walk_last = (walk_r == rlysh_pkg::CH_AW'(rlysh_pkg::CHANNELS - 1));
  assign rd_addr       = cmd.walk_en ? walk_r : rlysh_pkg::CH_AW'(in_channel);

  // A channel counts when its bit went from clear to set since the last flush.
  always_comb begin
    rise = 1'b0;
    if (int'(walk_r) < rlysh_pkg::IMG_BITS) begin
      rise = img_r[rlysh_pkg::IMG_AW'(walk_r)] & ~prev_r[rlysh_pkg::IMG_AW'(walk_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r <= '0;
    end else if (cmd.clear_img) begin
      img_r <= '0;
    end else if (cmd.set_bit && ch_in_img) begin
      img_r[rlysh_pkg::IMG_AW'(in_channel)] <= in_turn_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.copy_prev) begin
      prev_r <= img_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      walk_r <= '0;
    end else if (cmd.flush_init) begin
      idx_r  <= rlysh_pkg::BYTE_AW'(rlysh_pkg::TOTAL_BYTES - 1);
      walk_r <= '0;
    end else begin
      if (cmd.shift_en) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cmd.walk_en) begin
        walk_r <= walk_r + 1'b1;
      end
    end
  end

  // Counter memory: read one channel, write back the previous one.
  always_ff @(posedge clk) begin
    rd_data_r <= cnt_mem_r[rd_addr];
    if (wb_vld_r && wb_rise_r) begin
      cnt_mem_r[wb_addr_r] <= (rd_vld_r ? rd_data_r : '0) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (wb_vld_r && wb_rise_r) begin
      cnt_vld_r[wb_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= cnt_vld_r[rd_addr];
    wb_rise_r <= rise;
    wb_addr_r <= walk_r;
    if (cmd.rd_cnt) begin
      rd_in_range_r <= (int'(in_channel) < rlysh_pkg::CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wb_vld_r    <= cmd.walk_en;
      out_valid_r <= cmd.shift_en | cmd.emit_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      out_shift_byte_r <= img_r[8*idx_r +: 8];
      if (int'(idx_r) >= rlysh_pkg::INPUT_FIRST) begin
        out_board_select_r <= rlysh_pkg::BOARD_INPUT;
      end else if (int'(idx_r) >= rlysh_pkg::THERM_FIRST) begin
        out_board_select_r <= rlysh_pkg::BOARD_THERM;
      end else begin
        out_board_select_r <= rlysh_pkg::BOARD_IO;
      end
      out_latch_after_r  <= (int'(idx_r) == rlysh_pkg::INPUT_FIRST) ||
                            (int'(idx_r) == rlysh_pkg::THERM_FIRST) ||
                            (int'(idx_r) == rlysh_pkg::IO_FIRST);
      out_last_of_run_r  <= (idx_r == '0);
      out_count_valid_r  <= 1'b0;
      out_switch_count_r <= '0;
    end else if (cmd.emit_cnt) begin
      out_shift_byte_r   <= '0;
      out_board_select_r <= rlysh_pkg::BOARD_INPUT;
      out_latch_after_r  <= 1'b0;
      out_last_of_run_r  <= 1'b1;
      out_count_valid_r  <= rd_in_range_r;
      out_switch_count_r <= (rd_in_range_r && rd_vld_r) ? rd_data_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shift_byte   = out_shift_byte_r;
  assign out_board_select = out_board_select_r;
  assign out_latch_after  = out_latch_after_r;
  assign out_last_of_run  = out_last_of_run_r;
  assign out_count_valid  = out_count_valid_r;
  assign out_switch_count = out_switch_count_r;

  `RLYSH_ASSERT_IMP(a_flush_end_latches, out_valid_r && out_last_of_run_r && !out_count_valid_r, out_latch_after_r)
  `RLYSH_ASSERT_IMP(a_count_is_lone_result, out_valid_r && out_count_valid_r, out_last_of_run_r && (out_shift_byte_r == 8'd0))
  `RLYSH_ASSERT_IMP(a_writeback_not_on_read, wb_vld_r, !cmd.rd_cnt && !cmd.emit_cnt)

endmodule

>>> design/relay_image_shift_out_with_cycle_count_unit.sv
// Top level of the relay image unit: shift-out flush and per-channel rising-edge counters.
//
//   channel   direction  handshake             fields
//   input     in         start / busy          in_mode, in_channel, in_turn_on
//   result    out        out_valid (strobe)    out_shift_byte, out_board_select,
//                                              out_latch_after, out_last_of_run,
//                                              out_count_valid, out_switch_count
//
// An item transfers on a rising edge with start high and busy low.
// Set/clear, clear and unused modes finish in the transfer cycle; busy stays low.
// A counter read raises busy in the read state; its memory read registers at transfer and
// its result registers in the read state. A flush holds busy while it shifts out the image
// bytes, walks every channel through the counter memory port, then copies the image.
// Each result sits on the ports for one cycle with out_valid; the receiver cannot stall.
// Reset is synchronous and active low; counter entries read as zero until first written.
`include "relay_image_shift_out_with_cycle_count_unit_defines.svh"
module relay_image_shift_out_with_cycle_count_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_mode,
  input  logic [5:0]                    in_channel,
  input  logic                          in_turn_on,
  output logic                          out_valid,
  output logic [7:0]                    out_shift_byte,
  output logic [1:0]                    out_board_select,
  output logic                          out_latch_after,
  output logic                          out_last_of_run,
  output logic                          out_count_valid,
  output logic [rlysh_pkg::CNT_W-1:0]   out_switch_count
);

  // Commands from the sequencer, status back from the datapath.
  rlysh_pkg::cmd_t cmd;
  rlysh_pkg::sts_t sts;

  // Sequencer: decode the transferred mode and step through shift-out and counter walk.
  rlysh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Datapath: hold the image, count rising edges, register each result.
  rlysh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_channel       (in_channel),
    .in_turn_on       (in_turn_on),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_shift_byte   (out_shift_byte),
    .out_board_select (out_board_select),
    .out_latch_after  (out_latch_after),
    .out_last_of_run  (out_last_of_run),
    .out_count_valid  (out_count_valid),
    .out_switch_count (out_switch_count)
  );

endmodule

>>> tb/tb_relay_image_shift_out_with_cycle_count_unit.sv
// Self-checking testbench for the relay image shift-out unit with rising-edge counters.
`timescale 1ns / 100ps

module tb_relay_image_shift_out_with_cycle_count_unit;

  // Modes 5 to 7 carry no meaning; the unit drops them without any result.
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  // One result transfer as it should appear on the out_ ports.
  typedef struct {
    logic [7:0]                  shift_byte;
    logic [1:0]                  board_select;
    logic                        latch_after;
    logic                        last_of_run;
    logic                        count_valid;
    logic [rlysh_pkg::CNT_W-1:0] switch_count;
  } relay_out_t;

  // Shadow copy of the relay image, the image seen at the last flush and the
  // per-channel rise counters. Each accepted command updates the shadow and
  // queues the transfers it must cause; each result transfer is checked
  // against the oldest queued one.
  class relay_image_shadow;
    logic [7:0]                  image [rlysh_pkg::TOTAL_BYTES];
    logic [7:0]                  prev_image [rlysh_pkg::TOTAL_BYTES];
    logic [rlysh_pkg::CNT_W-1:0] rise_counts [rlysh_pkg::CHANNELS];
    relay_out_t                  pending_outputs [$];
    int errors, n_commands, n_flushes, n_reads, n_checked, n_rises;

    function new();
      foreach (image[i]) begin
        image[i] = '0;
        prev_image[i] = '0;
      end
      foreach (rise_counts[i]) rise_counts[i] = '0;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    // Queue one board's bytes, highest byte first, latch on its lowest byte.
    function void queue_board(int first, int nbytes, logic [1:0] board);
      relay_out_t r;
      for (int n = nbytes; n > 0; n--) begin
        r.shift_byte   = image[first + n - 1];
        r.board_select = board;
        r.latch_after  = (n == 1);
        r.last_of_run  = 1'b0;
        r.count_valid  = 1'b0;
        r.switch_count = '0;
        pending_outputs.push_back(r);
      end
    endfunction

    function void flush_image();
      int byte_idx;
      queue_board(rlysh_pkg::INPUT_FIRST, rlysh_pkg::INPUT_BYTES, rlysh_pkg::BOARD_INPUT);
      queue_board(rlysh_pkg::THERM_FIRST, rlysh_pkg::THERM_BYTES, rlysh_pkg::BOARD_THERM);
      queue_board(rlysh_pkg::IO_FIRST, rlysh_pkg::IO_BYTES, rlysh_pkg::BOARD_IO);
      pending_outputs[pending_outputs.size() - 1].last_of_run = 1'b1;
      for (int c = 0; c < rlysh_pkg::CHANNELS; c++) begin
        byte_idx = c / 8;
        if (byte_idx < rlysh_pkg::TOTAL_BYTES && !prev_image[byte_idx][c % 8] &&
            image[byte_idx][c % 8]) begin
          rise_counts[c] = rise_counts[c] + 1'b1;
          n_rises++;
        end
      end
      prev_image = image;
      n_flushes++;
    endfunction

    function void note_command(logic [2:0] mode, logic [5:0] channel, logic turn_on);
      relay_out_t r;
      n_commands++;
      case (mode)
        rlysh_pkg::MODE_SET: begin
          if (channel / 8 < rlysh_pkg::TOTAL_BYTES) begin
            image[channel / 8][channel % 8] = turn_on;
          end
        end
        rlysh_pkg::MODE_CLR: begin
          foreach (image[i]) image[i] = '0;
        end
        rlysh_pkg::MODE_FLUSH: flush_image();
        rlysh_pkg::MODE_CLR_FLUSH: begin
          foreach (image[i]) image[i] = '0;
          flush_image();
        end
        rlysh_pkg::MODE_READ: begin
          r.shift_byte   = '0;
          r.board_select = '0;
          r.latch_after  = 1'b0;
          r.last_of_run  = 1'b1;
          r.count_valid  = (channel < rlysh_pkg::CHANNELS);
          r.switch_count = (channel < rlysh_pkg::CHANNELS) ? rise_counts[channel] : '0;
          pending_outputs.push_back(r);
          n_reads++;
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [rlysh_pkg::CNT_W-1:0] exp_v,
                            logic [rlysh_pkg::CNT_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_output(relay_out_t got);
      relay_out_t want;
      if (pending_outputs.size() == 0) begin
        $error("result transfer with nothing expected (shift_byte 0x%0h, count 0x%0h)",
               got.shift_byte, got.switch_count);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      n_checked++;
      cmp_field("out_shift_byte", want.shift_byte, got.shift_byte);
      cmp_field("out_board_select", want.board_select, got.board_select);
      cmp_field("out_latch_after", want.latch_after, got.latch_after);
      cmp_field("out_last_of_run", want.last_of_run, got.last_of_run);
      cmp_field("out_count_valid", want.count_valid, got.count_valid);
      cmp_field("out_switch_count", want.switch_count, got.switch_count);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [2:0]                  in_mode = rlysh_pkg::MODE_SET;
  logic [5:0]                  in_channel = '0;
  logic                        in_turn_on = 1'b0;
  logic                        out_valid;
  logic [7:0]                  out_shift_byte;
  logic [1:0]                  out_board_select;
  logic                        out_latch_after;
  logic                        out_last_of_run;
  logic                        out_count_valid;
  logic [rlysh_pkg::CNT_W-1:0] out_switch_count;

  relay_image_shadow shadow = new();

  relay_image_shift_out_with_cycle_count_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_channel       (in_channel),
    .in_turn_on       (in_turn_on),
    .out_valid        (out_valid),
    .out_shift_byte   (out_shift_byte),
    .out_board_select (out_board_select),
    .out_latch_after  (out_latch_after),
    .out_last_of_run  (out_last_of_run),
    .out_count_valid  (out_count_valid),
    .out_switch_count (out_switch_count)
  );

  // 12 ns clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Watch both channels at every rising edge. Check the result strobe first,
  // then note a command transfer, so a result never meets an expectation
  // queued in the same edge. All sampled values are the pre-edge ones.
  always @(posedge clk) begin
    relay_out_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.shift_byte   = out_shift_byte;
        got.board_select = out_board_select;
        got.latch_after  = out_latch_after;
        got.last_of_run  = out_last_of_run;
        got.count_valid  = out_count_valid;
        got.switch_count = out_switch_count;
        shadow.check_output(got);
      end
      if (start && !busy) shadow.note_command(in_mode, in_channel, in_turn_on);
    end
  end

  // Present one command and hold it until it transfers. Before it, idle the
  // sender cycle by cycle with the given chance, so that about idle_pct cycles
  // in a hundred carry no command. Leave start high on return so a following
  // command can transfer in the very next cycle.
  task automatic send_command(input logic [2:0] mode, input logic [5:0] channel,
                              input logic turn_on, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= mode;
    in_channel <= channel;
    in_turn_on <= turn_on;
    do @(posedge clk); while (busy);
  endtask

  // Hard stop in case the unit hangs: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("tb_relay_image_shift_out_with_cycle_count_unit failed");
    $finish;
  end

  initial begin
    int sent;
    int idle_pct;
    int pick;
    int waited;
    logic [2:0] mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: channel extremes and board boundaries, both bit values,
    // a repeated rise so a counter reaches two, a clear, a clear-and-flush,
    // reads of counted and never-counted channels, and the unused modes.
    send_command(rlysh_pkg::MODE_SET, 6'd0, 1'b1, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd63, 1'b1, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd7, 1'b1, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd8, 1'b1, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd32, 1'b1, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd48, 1'b1, 20);
    send_command(rlysh_pkg::MODE_FLUSH, 6'd0, 1'b0, 20);
    send_command(rlysh_pkg::MODE_READ, 6'd0, 1'b0, 20);
    send_command(rlysh_pkg::MODE_READ, 6'd63, 1'b1, 20);
    send_command(rlysh_pkg::MODE_READ, 6'd5, 1'b0, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd0, 1'b0, 20);
    send_command(rlysh_pkg::MODE_SET, 6'd63, 1'b0, 20);
    send_command(rlysh_pkg::MODE_FLUSH, 6'd0, 1'b0, 0);
    send_command(rlysh_pkg::MODE_SET, 6'd0, 1'b1, 0);
    send_command(rlysh_pkg::MODE_FLUSH, 6'd0, 1'b0, 0);
    send_command(rlysh_pkg::MODE_READ, 6'd0, 1'b0, 0);
    send_command(MODE_UNUSED_FIRST, 6'd63, 1'b1, 0);
    send_command(MODE_UNUSED_FIRST + 3'd1, 6'd21, 1'b0, 0);
    send_command(MODE_UNUSED_LAST, 6'd42, 1'b1, 0);
    send_command(rlysh_pkg::MODE_CLR, 6'd63, 1'b1, 0);
    send_command(rlysh_pkg::MODE_FLUSH, 6'd0, 1'b0, 0);
    send_command(rlysh_pkg::MODE_SET, 6'd55, 1'b1, 0);
    send_command(rlysh_pkg::MODE_CLR_FLUSH, 6'd0, 1'b0, 0);
    send_command(rlysh_pkg::MODE_READ, 6'd55, 1'b0, 0);

    // Random part: mostly bit set/clear so that channels keep toggling between
    // flushes and the counters advance. Unused modes are noise and do not
    // count toward the total. Idle the sender at 20 %, then 61 %, then never.
    sent = 0;
    while (sent < 400) begin
      idle_pct = (sent < 133) ? 20 : (sent < 266) ? 61 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)      mode = rlysh_pkg::MODE_SET;
      else if (pick < 70) mode = rlysh_pkg::MODE_FLUSH;
      else if (pick < 85) mode = rlysh_pkg::MODE_READ;
      else if (pick < 89) mode = rlysh_pkg::MODE_CLR;
      else if (pick < 93) mode = rlysh_pkg::MODE_CLR_FLUSH;
      else                mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      send_command(mode, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), idle_pct);
      if (mode < MODE_UNUSED_FIRST) sent++;
    end
    start <= 1'b0;

    // Drain: wait for every queued transfer, then hold past one full flush
    // so that any stray result still shows up.
    waited = 0;
    do @(posedge clk); while (shadow.pending() != 0 && waited++ < 2000);
    repeat (80) @(posedge clk);

    if (shadow.pending() != 0) begin
      $error("%0d expected result transfers never arrived", shadow.pending());
      shadow.errors++;
    end

    $display("Covered %0d commands: %0d flushes and %0d counter reads.",
             shadow.n_commands, shadow.n_flushes, shadow.n_reads);
    $display("Checked %0d result transfers; %0d channel rises were counted.",
             shadow.n_checked, shadow.n_rises);
    if (shadow.errors == 0) begin
      $display("tb_relay_image_shift_out_with_cycle_count_unit passed");
    end else begin
      $display("tb_relay_image_shift_out_with_cycle_count_unit failed");
    end
    $finish;
  end

endmodule
